/* src/cvr_pkg.sv */
// shared types and constants for the collision velocity resolver
package cvr_pkg;

    localparam logic [1:0] KIND_BALL = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;

    typedef enum logic [1:0] {
        ST_BALL_BALL   = 2'd0,
        ST_BALL_LINE   = 2'd1,
        ST_UNSUPPORTED = 2'd2,
        ST_ERROR       = 2'd3
    } status_t;

endpackage

/* src/collision_velocity_resolver.sv */
// top level: two-body elastic collision response, ball-ball and ball-line
// pipeline depth is dominated by the bit-per-stage quotient divider
// throughput: one transfer per cycle; the whole pipeline advances only when the
// output register is free or being taken
// reset: aresetn clears the valid bits only; nothing else is reset
module collision_velocity_resolver #(
    parameter int VEL_WIDTH     = 24,
    parameter int MASS_WIDTH    = 16,
    parameter int DIR_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind_a,
    input  logic [1:0]                    s_kind_b,
    input  logic signed [VEL_WIDTH-1:0]   s_vel_a_x,
    input  logic signed [VEL_WIDTH-1:0]   s_vel_a_y,
    input  logic [MASS_WIDTH-1:0]         s_mass_a,
    input  logic signed [VEL_WIDTH-1:0]   s_vel_b_x,
    input  logic signed [VEL_WIDTH-1:0]   s_vel_b_y,
    input  logic [MASS_WIDTH-1:0]         s_mass_b,
    input  logic signed [DIR_FRAC_BITS+1:0] s_line_dir_x,
    input  logic signed [DIR_FRAC_BITS+1:0] s_line_dir_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VEL_WIDTH-1:0]   m_new_vel_a_x,
    output logic signed [VEL_WIDTH-1:0]   m_new_vel_a_y,
    output logic signed [VEL_WIDTH-1:0]   m_new_vel_b_x,
    output logic signed [VEL_WIDTH-1:0]   m_new_vel_b_y,
    output logic [1:0]                    m_status,
    output logic                          m_saturated
);
    import cvr_pkg::*;

    localparam int DW   = DIR_FRAC_BITS + 2;
    localparam int MW1  = MASS_WIDTH + 1;          // signed mass difference
    localparam int PW   = VEL_WIDTH + MASS_WIDTH + 2; // product width
    localparam int NUMW = PW + 1;                  // numerator
    localparam int DOTW = VEL_WIDTH + DW + 1;
    localparam int RW   = NUMW;                    // common wide result width
    localparam int LAT  = NUMW + 5;                // valid pipe length

    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // valid pipe
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: classify, mass sum and difference, doubled masses, line normal
    logic [1:0] st1_reg;
    logic       ball_a1_reg;
    logic signed [VEL_WIDTH-1:0] va1_reg [4];
    logic signed [MW1:0]         diff1_reg;
    logic [MASS_WIDTH:0]         tot1_reg;
    logic signed [MASS_WIDTH+1:0] ma2_1_reg, mb2_1_reg;
    logic signed [DW:0]          nx1_reg, ny1_reg;
    logic [1:0] st_next;

    always_comb begin
        if (s_kind_a > KIND_LINE || s_kind_b > KIND_LINE)      st_next = ST_UNSUPPORTED;
        else if (s_kind_a == KIND_LINE && s_kind_b == KIND_LINE) st_next = ST_ERROR;
        else if (s_kind_a == KIND_BALL && s_kind_b == KIND_BALL) begin
            st_next = ({1'b0, s_mass_a} + {1'b0, s_mass_b} == '0) ? ST_ERROR : ST_BALL_BALL;
        end else st_next = ST_BALL_LINE;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_reg     <= st_next;
            ball_a1_reg <= s_kind_a == KIND_BALL;
            va1_reg[0]  <= s_vel_a_x;
            va1_reg[1]  <= s_vel_a_y;
            va1_reg[2]  <= s_vel_b_x;
            va1_reg[3]  <= s_vel_b_y;
            diff1_reg   <= $signed({2'b00, s_mass_a}) - $signed({2'b00, s_mass_b});
            tot1_reg    <= {1'b0, s_mass_a} + {1'b0, s_mass_b};
            ma2_1_reg   <= $signed({1'b0, s_mass_a, 1'b0});
            mb2_1_reg   <= $signed({1'b0, s_mass_b, 1'b0});
            nx1_reg     <= -(DW+1)'(s_line_dir_y);
            ny1_reg     <= (DW+1)'(s_line_dir_x);
        end
    end

    // stage 2: products (ball-ball numerators terms, dot product terms)
    logic [1:0] st2_reg;
    logic       ball_a2_reg;
    logic signed [VEL_WIDTH-1:0] va2_reg [4];
    logic [MASS_WIDTH:0]         tot2_reg;
    logic signed [PW-1:0]        pd_reg [4];   // diff * own vel
    logic signed [PW-1:0]        pc_reg [4];   // 2*m_other * other vel
    logic signed [DOTW-1:0]      dx2_reg, dy2_reg;
    logic signed [DW:0]          nx2_reg, ny2_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            st2_reg     <= st1_reg;
            ball_a2_reg <= ball_a1_reg;
            va2_reg     <= va1_reg;
            tot2_reg    <= tot1_reg;
            pd_reg[0]   <= PW'(diff1_reg * va1_reg[0]);
            pd_reg[1]   <= PW'(diff1_reg * va1_reg[1]);
            pd_reg[2]   <= PW'(-diff1_reg * va1_reg[2]);
            pd_reg[3]   <= PW'(-diff1_reg * va1_reg[3]);
            pc_reg[0]   <= PW'(mb2_1_reg * va1_reg[2]);
            pc_reg[1]   <= PW'(mb2_1_reg * va1_reg[3]);
            pc_reg[2]   <= PW'(ma2_1_reg * va1_reg[0]);
            pc_reg[3]   <= PW'(ma2_1_reg * va1_reg[1]);
            dx2_reg <= DOTW'((ball_a1_reg ? va1_reg[0] : va1_reg[2]) * nx1_reg);
            dy2_reg <= DOTW'((ball_a1_reg ? va1_reg[1] : va1_reg[3]) * ny1_reg);
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
        end
    end

    // stage 3: numerators, rounded projection
    logic [1:0] st3_reg;
    logic       ball_a3_reg;
    logic signed [VEL_WIDTH-1:0] va3_reg [4];
    logic [MASS_WIDTH:0]         tot3_reg;
    logic signed [NUMW-1:0]      num3_reg [4];
    logic signed [DOTW-DIR_FRAC_BITS+1:0] p3_reg;
    logic signed [DW:0]          nx3_reg, ny3_reg;
    logic signed [DOTW:0]        dsum;

    assign dsum = (DOTW+1)'(dx2_reg) + (DOTW+1)'(dy2_reg)
                + (DOTW+1)'(1 <<< (DIR_FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (advance) begin
            st3_reg     <= st2_reg;
            ball_a3_reg <= ball_a2_reg;
            va3_reg     <= va2_reg;
            tot3_reg    <= tot2_reg;
            for (int i = 0; i < 4; i++) begin
                num3_reg[i] <= NUMW'(pd_reg[i]) + NUMW'(pc_reg[i]);
            end
            // arithmetic shift is floor
            p3_reg  <= (DOTW-DIR_FRAC_BITS+2)'(dsum >>> DIR_FRAC_BITS);
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
        end
    end

    // stage 4: correction products for reflection
    localparam int CW = DOTW - DIR_FRAC_BITS + 2 + DW + 2;
    logic signed [CW-1:0] cx4_reg, cy4_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            cx4_reg <= CW'(p3_reg * nx3_reg) <<< 1;
            cy4_reg <= CW'(p3_reg * ny3_reg) <<< 1;
        end
    end

    // dividers for the four ball-ball components
    logic signed [NUMW-1:0] quot [4];
    for (genvar k = 0; k < 4; k++) begin : g_div
        cvr_divider #(.NUM_WIDTH(NUMW), .DEN_WIDTH(MASS_WIDTH + 1)) u_div (
            .aclk (aclk),
            .en   (advance),
            .num  (num3_reg[k]),
            .den  (tot3_reg),
            .quot (quot[k])
        );
    end

    // side line: carries the rest of the item alongside the divider
    localparam int SD = NUMW;
    logic [1:0] sst_reg [SD];
    logic       sba_reg [SD];
    logic signed [VEL_WIDTH-1:0] sva_reg [SD][4];
    logic signed [RW-1:0]        sref_reg [SD][2];

    logic signed [CW:0] rx4, ry4;
    assign rx4 = (CW+1)'(cx4_reg) + (CW+1)'(1 <<< (DIR_FRAC_BITS - 1));
    assign ry4 = (CW+1)'(cy4_reg) + (CW+1)'(1 <<< (DIR_FRAC_BITS - 1));

    // stage-3 copies registered once more to line up with the correction products
    logic [1:0] st4_reg;
    logic       ba4_reg;
    logic signed [VEL_WIDTH-1:0] va4_reg [4];
    always_ff @(posedge aclk) begin
        if (advance) begin
            st4_reg <= st3_reg;
            ba4_reg <= ball_a3_reg;
            va4_reg <= va3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sst_reg[0] <= st4_reg;
            sba_reg[0] <= ba4_reg;
            sva_reg[0] <= va4_reg;
            sref_reg[0][0] <= RW'(ba4_reg ? va4_reg[0] : va4_reg[2]) - RW'(rx4 >>> DIR_FRAC_BITS);
            sref_reg[0][1] <= RW'(ba4_reg ? va4_reg[1] : va4_reg[3]) - RW'(ry4 >>> DIR_FRAC_BITS);
            for (int j = 1; j < SD; j++) begin
                sst_reg[j]  <= sst_reg[j-1];
                sba_reg[j]  <= sba_reg[j-1];
                sva_reg[j]  <= sva_reg[j-1];
                sref_reg[j] <= sref_reg[j-1];
            end
        end
    end

    // final: select and saturate
    localparam logic signed [RW-1:0] VMAX = RW'((64'sd1 <<< (VEL_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

    logic signed [RW-1:0]        wide [4];
    logic [3:0]                  use_wide;
    logic signed [VEL_WIDTH-1:0] res [4];
    logic                        clip;
    logic [1:0]                  fst;

    always_comb begin
        fst = sst_reg[SD-1];
        for (int i = 0; i < 4; i++) begin
            wide[i] = quot[i];
        end
        use_wide = 4'b0000;
        case (fst)
            ST_BALL_BALL: use_wide = 4'b1111;
            ST_BALL_LINE: begin
                if (sba_reg[SD-1]) begin
                    wide[0] = sref_reg[SD-1][0];
                    wide[1] = sref_reg[SD-1][1];
                    use_wide = 4'b0011;
                end else begin
                    wide[2] = sref_reg[SD-1][0];
                    wide[3] = sref_reg[SD-1][1];
                    use_wide = 4'b1100;
                end
            end
            default: use_wide = 4'b0000;
        endcase
        clip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (!use_wide[i]) begin
                res[i] = sva_reg[SD-1][i];
            end else if (wide[i] > VMAX) begin
                res[i] = VEL_WIDTH'(VMAX);
                clip   = 1'b1;
            end else if (wide[i] < VMIN) begin
                res[i] = VEL_WIDTH'(VMIN);
                clip   = 1'b1;
            end else begin
                res[i] = VEL_WIDTH'(wide[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_new_vel_a_x <= res[0];
            m_new_vel_a_y <= res[1];
            m_new_vel_b_x <= res[2];
            m_new_vel_b_y <= res[3];
            m_status      <= fst;
            m_saturated   <= clip;
        end
    end

    assign m_valid = vld_reg[LAT-1];

`ifndef SYNTH
    // a stalled output must not be overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_vel_a_x) && $stable(m_status))
        else $error("output changed while stalled");
    // unchanged pairs never report clipping
    a_noclip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_UNSUPPORTED || m_status == ST_ERROR) |-> !m_saturated)
        else $error("clip flagged on pass-through");
    // input is taken exactly when the pipeline advances
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready out of step with output");
`endif
endmodule

/* src/cvr_divider.sv */
// pipelined restoring divider, signed numerator by unsigned divisor, one quotient bit per stage
module cvr_divider #(
    parameter int NUM_WIDTH = 58,
    parameter int DEN_WIDTH = 17
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [NUM_WIDTH-1:0] num,
    input  logic        [DEN_WIDTH-1:0] den,
    output logic signed [NUM_WIDTH-1:0] quot
);
    localparam int MAG_WIDTH = NUM_WIDTH;

    logic [MAG_WIDTH-1:0] q_reg   [MAG_WIDTH+1];
    logic [DEN_WIDTH:0]   rem_reg [MAG_WIDTH+1];
    logic [DEN_WIDTH-1:0] den_reg [MAG_WIDTH+1];
    logic                 neg_reg [MAG_WIDTH+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]   <= num[NUM_WIDTH-1] ? MAG_WIDTH'(-num) : MAG_WIDTH'(num);
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= num[NUM_WIDTH-1];
        end
    end

    for (genvar i = 0; i < MAG_WIDTH; i++) begin : g_stage
        logic [DEN_WIDTH+1:0] trial;
        logic                 fits;
        assign trial = {rem_reg[i], q_reg[i][MAG_WIDTH-1]};
        assign fits  = trial >= {2'b00, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= fits ? (DEN_WIDTH+1)'(trial - {2'b00, den_reg[i]})
                                     : (DEN_WIDTH+1)'(trial);
                q_reg[i+1]   <= {q_reg[i][MAG_WIDTH-2:0], fits};
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign quot = neg_reg[MAG_WIDTH] ? -$signed(q_reg[MAG_WIDTH])
                                     : $signed(q_reg[MAG_WIDTH]);
endmodule
